### hw/rtl/gvu_pkg.sv
package gvu_pkg;

  localparam int MAX_BODIES_DEF = 1024;

  // Field widths.
  localparam int ID_W       = 16;
  localparam int POS_W      = 32;
  localparam int MASS_W     = 32;
  localparam int VEL_W      = 48;
  localparam int SKIP_W     = 11;
  localparam int G_W        = 32;
  localparam int DMIN_W     = 63;
  localparam int AMAX_W     = 47;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 63;

  // Datapath widths.
  localparam int DIFF_W     = POS_W + 1;
  localparam int D2_W       = 2 * DIFF_W;
  localparam int ROOT_W     = 34;
  localparam int SQ_REM_W   = 36;
  localparam int SQRT_STEPS = D2_W / 2;
  localparam int LIMB_W     = 32;
  localparam int MUL_LIMBS  = 3;
  localparam int MUL_A_W    = LIMB_W * MUL_LIMBS;
  localparam int MUL_B_W    = ROOT_W;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W  = 2;
  localparam int GM_W       = G_W + MASS_W;
  localparam int DEN_W      = D2_W + ROOT_W;
  localparam int FRAC_SHIFT = 16;
  localparam int PROD_N_W   = GM_W + DIFF_W;
  localparam int NUM_W      = PROD_N_W + FRAC_SHIFT;
  localparam int QUO_W      = 63;
  localparam int ACC_W      = 64;

  localparam logic [G_W-1:0]    G_RESET    = G_W'(64'd16777216);
  localparam logic [DMIN_W-1:0] DMIN_RESET = DMIN_W'(64'd16777216);
  localparam logic [AMAX_W-1:0] AMAX_RESET = AMAX_W'(64'd6553600000);

  localparam logic KIND_TARGET = 1'b0;
  localparam logic KIND_BODY   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAVITY   = 2'd0,
    REG_MIN_DIST2 = 2'd1,
    REG_MAX_ACCEL = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    MUL_SQX,
    MUL_SQY,
    MUL_DEN,
    MUL_GM,
    MUL_NUMX,
    MUL_NUMY
  } mul_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_CHECK,
    ST_SQRT,
    ST_DEN,
    ST_GM,
    ST_NUMX,
    ST_NUMY,
    ST_DIV,
    ST_ACC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic    accept;
    logic    mul_start;
    mul_op_t mul_sel;
    logic    sqrt_start;
    logic    div_start;
    logic    close_inc;
    logic    acc_upd;
    logic    result_wr;
  } cmd_t;

  typedef struct packed {
    logic in_kind;
    logic in_same_id;
    logic in_last;
    logic item_last;
    logic too_close;
    logic mul_done;
    logic sqrt_done;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

### hw/rtl/gvu_if.sv
interface gvu_in_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic [gvu_pkg::ID_W-1:0]          body_id;
  logic signed [gvu_pkg::POS_W-1:0]  pos_x;
  logic signed [gvu_pkg::POS_W-1:0]  pos_y;
  logic [gvu_pkg::MASS_W-1:0]        mass;
  logic signed [gvu_pkg::VEL_W-1:0]  vel_x;
  logic signed [gvu_pkg::VEL_W-1:0]  vel_y;
  logic                              last;
  modport source (output valid, kind, body_id, pos_x, pos_y, mass, vel_x, vel_y, last,
                  input ready);
  modport sink (input valid, kind, body_id, pos_x, pos_y, mass, vel_x, vel_y, last,
                output ready);
endinterface

interface gvu_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [gvu_pkg::VEL_W-1:0]  new_vel_x;
  logic signed [gvu_pkg::VEL_W-1:0]  new_vel_y;
  logic                              status;
  logic [gvu_pkg::SKIP_W-1:0]        close_skips;
  modport source (output valid, new_vel_x, new_vel_y, status, close_skips, input ready);
  modport sink (input valid, new_vel_x, new_vel_y, status, close_skips, output ready);
endinterface

interface gvu_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [gvu_pkg::CFG_IDX_W-1:0]     index;
  logic [gvu_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/gvu_mul.sv
module gvu_mul (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [gvu_pkg::MUL_A_W-1:0]     a,
  input  logic [gvu_pkg::MUL_B_W-1:0]     b,
  input  logic [gvu_pkg::MUL_CNT_W-1:0]   limbs,
  output logic                            busy,
  output logic                            done,
  output logic [gvu_pkg::MUL_P_W-1:0]     prod
);

  localparam int AW = gvu_pkg::MUL_A_W;
  localparam int BW = gvu_pkg::MUL_B_W;
  localparam int PW = gvu_pkg::MUL_P_W;
  localparam int LW = gvu_pkg::LIMB_W;

  logic [AW-1:0]                   a_sh;
  logic [AW-1:0]                   a_align;
  logic [BW-1:0]                   b_reg;
  logic [gvu_pkg::MUL_CNT_W-1:0]   cnt;
  logic [LW+BW-1:0]                pp;

  // Left-align the operand so the most significant used limb is processed first.
  always_comb begin
    case (limbs)
      gvu_pkg::MUL_CNT_W'(1): a_align = a << (2 * LW);
      gvu_pkg::MUL_CNT_W'(2): a_align = a << LW;
      default:                a_align = a;
    endcase
  end

  assign pp = (LW + BW)'(a_sh[AW-1 -: LW]) * (LW + BW)'(b_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == gvu_pkg::MUL_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh  <= a_align;
      b_reg <= b;
      cnt   <= limbs;
      prod  <= '0;
    end else if (busy) begin
      a_sh <= a_sh << LW;
      cnt  <= cnt - gvu_pkg::MUL_CNT_W'(1);
      prod <= {prod[PW-LW-1:0], LW'(0)} + PW'(pp);
    end
  end

endmodule

### hw/rtl/gvu_div.sv
module gvu_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [gvu_pkg::NUM_W-1:0]     num_x,
  input  logic [gvu_pkg::NUM_W-1:0]     num_y,
  input  logic [gvu_pkg::DEN_W-1:0]     den,
  output logic                          busy,
  output logic                          done,
  output logic [gvu_pkg::QUO_W-1:0]     quo_x,
  output logic [gvu_pkg::QUO_W-1:0]     quo_y
);

  localparam int QW    = gvu_pkg::QUO_W;
  localparam int DW    = gvu_pkg::DEN_W;
  localparam int NW    = gvu_pkg::NUM_W;
  localparam int CNT_W = $clog2(QW + 1);

  logic [DW-1:0]    rem_x, rem_y;
  logic [QW-1:0]    sh_x, sh_y;
  logic             sat_x, sat_y;
  logic [CNT_W-1:0] cnt;
  logic [DW:0]      r2_x, r2_y, df_x, df_y;
  logic             ge_x, ge_y;

  // The quotient saturates exactly when the numerator's upper part reaches the divisor;
  // otherwise it fits in QW bits and a QW-step restoring loop produces it.
  always_comb begin
    r2_x = {rem_x, sh_x[QW-1]};
    r2_y = {rem_y, sh_y[QW-1]};
    df_x = r2_x - {1'b0, den};
    df_y = r2_y - {1'b0, den};
    ge_x = r2_x >= {1'b0, den};
    ge_y = r2_y >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_x <= DW'(num_x[NW-1:QW]);
      rem_y <= DW'(num_y[NW-1:QW]);
      sat_x <= DW'(num_x[NW-1:QW]) >= den;
      sat_y <= DW'(num_y[NW-1:QW]) >= den;
      sh_x  <= num_x[QW-1:0];
      sh_y  <= num_y[QW-1:0];
      cnt   <= CNT_W'(QW);
    end else if (busy) begin
      rem_x <= ge_x ? df_x[DW-1:0] : r2_x[DW-1:0];
      rem_y <= ge_y ? df_y[DW-1:0] : r2_y[DW-1:0];
      sh_x  <= {sh_x[QW-2:0], ge_x};
      sh_y  <= {sh_y[QW-2:0], ge_y};
      cnt   <= cnt - CNT_W'(1);
    end
  end

  assign quo_x = sat_x ? '1 : sh_x;
  assign quo_y = sat_y ? '1 : sh_y;

endmodule

### hw/rtl/gvu_dp.sv
module gvu_dp #(
  parameter int MAX_BODIES = gvu_pkg::MAX_BODIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  gvu_pkg::cmd_t                     cmd,
  output gvu_pkg::status_t                  stat,
  input  logic                              in_kind,
  input  logic [gvu_pkg::ID_W-1:0]          in_body_id,
  input  logic signed [gvu_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [gvu_pkg::POS_W-1:0]  in_pos_y,
  input  logic [gvu_pkg::MASS_W-1:0]        in_mass,
  input  logic signed [gvu_pkg::VEL_W-1:0]  in_vel_x,
  input  logic signed [gvu_pkg::VEL_W-1:0]  in_vel_y,
  input  logic                              in_last,
  input  logic                              cfg_valid,
  input  logic [gvu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gvu_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [gvu_pkg::VEL_W-1:0]  out_vel_x,
  output logic signed [gvu_pkg::VEL_W-1:0]  out_vel_y,
  output logic                              out_status,
  output logic [gvu_pkg::SKIP_W-1:0]        out_skips
);

  localparam int DFW = gvu_pkg::DIFF_W;
  localparam int PSW = gvu_pkg::POS_W;
  localparam int D2W = gvu_pkg::D2_W;
  localparam int RW  = gvu_pkg::ROOT_W;
  localparam int SRW = gvu_pkg::SQ_REM_W;
  localparam int AW  = gvu_pkg::ACC_W;
  localparam int VW  = gvu_pkg::VEL_W;
  localparam int QW  = gvu_pkg::QUO_W;
  localparam int SW  = gvu_pkg::SKIP_W;
  localparam int SQ_CNT_W = $clog2(gvu_pkg::SQRT_STEPS + 1);
  localparam int SKIP_MAX = (1 << SW) - 1;
  localparam int LIMIT    = (MAX_BODIES < SKIP_MAX) ? MAX_BODIES : SKIP_MAX;
  localparam logic [SW-1:0] SKIP_LIMIT = SW'(LIMIT);
  localparam logic signed [AW:0] ACC_HI = {2'b00, {(AW-1){1'b1}}};
  localparam logic signed [AW:0] VEL_HI = (AW+1)'({1'b0, {(VW-1){1'b1}}});

  // Configuration registers.
  logic [gvu_pkg::G_W-1:0]    gravity;
  logic [gvu_pkg::DMIN_W-1:0] min_d2;
  logic [gvu_pkg::AMAX_W-1:0] max_acc;

  // Target body and accumulated state.
  logic [gvu_pkg::ID_W-1:0]   target_id;
  logic [PSW-1:0]             target_x, target_y;
  logic [gvu_pkg::MASS_W-1:0] tgt_mass;
  logic signed [VW-1:0]       target_vx, target_vy;
  logic signed [AW-1:0]       acc_x, acc_y;
  logic [SW-1:0]              close_count;

  // Per-body working registers.
  logic [DFW-1:0]             adx, ady;
  logic                       neg_x, neg_y;
  logic [gvu_pkg::MASS_W-1:0] mass_r;
  logic                       item_last;
  logic [D2W-1:0]             sqx, d2;
  logic [gvu_pkg::DEN_W-1:0]  den;
  logic [gvu_pkg::GM_W-1:0]   gm;
  logic [gvu_pkg::NUM_W-1:0]  num_x;
  gvu_pkg::mul_op_t           cur_sel;

  // Square root registers.
  logic [D2W-1:0]      sq_rad;
  logic [SRW-1:0]      sq_rem;
  logic [RW-1:0]       root;
  logic [SQ_CNT_W-1:0] sq_cnt;
  logic                sq_busy, sq_done;
  logic [SRW+1:0]      sq_r2, sq_trial, sq_df;
  logic                sq_ge;

  // Shared units.
  logic [gvu_pkg::MUL_A_W-1:0]   mul_a;
  logic [gvu_pkg::MUL_B_W-1:0]   mul_b;
  logic [gvu_pkg::MUL_CNT_W-1:0] mul_limbs;
  logic                          mul_busy, mul_done;
  logic [gvu_pkg::MUL_P_W-1:0]   mul_prod;
  logic [gvu_pkg::NUM_W-1:0]     num_y_now;
  logic                          div_busy, div_done;
  logic [QW-1:0]                 quo_x, quo_y;

  logic signed [DFW-1:0] dxf, dyf;
  logic [DFW-1:0]        adx_now, ady_now;
  logic                  too_close;
  logic [AW-1:0]         mag_x, mag_y;
  logic                  skip_upd;
  logic signed [VW-1:0]  vx_upd, vy_upd, vx_res, vy_res;

  function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] a,
                                                   input logic [QW-1:0] t,
                                                   input logic neg);
    logic signed [AW:0] tt;
    logic signed [AW:0] s;
    tt = neg ? -$signed({2'b00, t}) : $signed({2'b00, t});
    s  = $signed({a[AW-1], a}) + tt;
    if (s > ACC_HI) begin
      return ACC_HI[AW-1:0];
    end else if (s < -ACC_HI) begin
      return AW'(-ACC_HI);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic signed [VW-1:0] sat_vel(input logic signed [VW-1:0] v,
                                                   input logic signed [AW-1:0] a);
    logic signed [AW:0] s;
    s = $signed({{(AW+1-VW){v[VW-1]}}, v}) + $signed({a[AW-1], a});
    if (s > VEL_HI) begin
      return VEL_HI[VW-1:0];
    end else if (s < -VEL_HI - (AW+1)'(1)) begin
      return {1'b1, {(VW-1){1'b0}}};
    end
    return s[VW-1:0];
  endfunction

  assign dxf = $signed({in_pos_x[PSW-1], in_pos_x}) - $signed({target_x[PSW-1], target_x});
  assign dyf = $signed({in_pos_y[PSW-1], in_pos_y}) - $signed({target_y[PSW-1], target_y});
  assign adx_now = dxf[DFW-1] ? DFW'(-dxf) : DFW'(dxf);
  assign ady_now = dyf[DFW-1] ? DFW'(-dyf) : DFW'(dyf);

  assign too_close = (d2 < D2W'(min_d2)) || (d2 == '0);

  assign mag_x    = acc_x[AW-1] ? AW'(-acc_x) : AW'(acc_x);
  assign mag_y    = acc_y[AW-1] ? AW'(-acc_y) : AW'(acc_y);
  assign skip_upd = (tgt_mass == '0) || (mag_x > AW'(max_acc)) || (mag_y > AW'(max_acc));
  assign vx_upd   = sat_vel(target_vx, acc_x);
  assign vy_upd   = sat_vel(target_vy, acc_y);
  assign vx_res   = skip_upd ? target_vx : vx_upd;
  assign vy_res   = skip_upd ? target_vy : vy_upd;

  always_comb begin
    stat            = '0;
    stat.in_kind    = in_kind;
    stat.in_same_id = in_body_id == target_id;
    stat.in_last    = in_last;
    stat.item_last  = item_last;
    stat.too_close  = too_close;
    stat.mul_done   = mul_done;
    stat.sqrt_done  = sq_done;
    stat.div_done   = div_done;
    stat.out_free   = !out_valid || out_ready;
  end

  // Operand selection. Where an operand is the product that just finished, it is taken
  // straight from the multiplier, since its register is written on that same edge. The
  // first square starts on the accepting edge, so it takes the difference from the request.
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mul_limbs = gvu_pkg::MUL_CNT_W'(1);
    case (cmd.mul_sel)
      gvu_pkg::MUL_SQX: begin
        mul_a     = gvu_pkg::MUL_A_W'(adx_now);
        mul_b     = gvu_pkg::MUL_B_W'(adx_now);
        mul_limbs = gvu_pkg::MUL_CNT_W'(2);
      end
      gvu_pkg::MUL_SQY: begin
        mul_a     = gvu_pkg::MUL_A_W'(ady);
        mul_b     = gvu_pkg::MUL_B_W'(ady);
        mul_limbs = gvu_pkg::MUL_CNT_W'(2);
      end
      gvu_pkg::MUL_DEN: begin
        mul_a     = gvu_pkg::MUL_A_W'(d2);
        mul_b     = root;
        mul_limbs = gvu_pkg::MUL_CNT_W'(3);
      end
      gvu_pkg::MUL_GM: begin
        mul_a     = gvu_pkg::MUL_A_W'(gravity);
        mul_b     = gvu_pkg::MUL_B_W'(mass_r);
        mul_limbs = gvu_pkg::MUL_CNT_W'(1);
      end
      gvu_pkg::MUL_NUMX: begin
        mul_a     = gvu_pkg::MUL_A_W'(mul_prod[gvu_pkg::GM_W-1:0]);
        mul_b     = gvu_pkg::MUL_B_W'(adx);
        mul_limbs = gvu_pkg::MUL_CNT_W'(2);
      end
      gvu_pkg::MUL_NUMY: begin
        mul_a     = gvu_pkg::MUL_A_W'(gm);
        mul_b     = gvu_pkg::MUL_B_W'(ady);
        mul_limbs = gvu_pkg::MUL_CNT_W'(2);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign num_y_now = {mul_prod[gvu_pkg::PROD_N_W-1:0], gvu_pkg::FRAC_SHIFT'(0)};

  gvu_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .limbs (mul_limbs),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  gvu_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num_x (num_x),
    .num_y (num_y_now),
    .den   (den),
    .busy  (div_busy),
    .done  (div_done),
    .quo_x (quo_x),
    .quo_y (quo_y)
  );

  // Digit-by-digit square root, two radicand bits per step.
  always_comb begin
    sq_r2    = {sq_rem, sq_rad[D2W-1 -: 2]};
    sq_trial = (SRW+2)'({root, 2'b01});
    sq_ge    = sq_r2 >= sq_trial;
    sq_df    = sq_r2 - sq_trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_done <= 1'b0;
    end else begin
      sq_done <= 1'b0;
      if (cmd.sqrt_start) begin
        sq_busy <= 1'b1;
      end else if (sq_busy && sq_cnt == SQ_CNT_W'(1)) begin
        sq_busy <= 1'b0;
        sq_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sq_rad <= d2;
      sq_rem <= '0;
      root   <= '0;
      sq_cnt <= SQ_CNT_W'(gvu_pkg::SQRT_STEPS);
    end else if (sq_busy) begin
      sq_rad <= sq_rad << 2;
      sq_rem <= sq_ge ? sq_df[SRW-1:0] : sq_r2[SRW-1:0];
      root   <= {root[RW-2:0], sq_ge};
      sq_cnt <= sq_cnt - SQ_CNT_W'(1);
    end
  end

  // Per-body working registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_last <= in_last;
      adx       <= adx_now;
      ady       <= ady_now;
      neg_x     <= dxf[DFW-1];
      neg_y     <= dyf[DFW-1];
      mass_r    <= in_mass;
    end
    if (cmd.mul_start) begin
      cur_sel <= cmd.mul_sel;
    end
    if (mul_done) begin
      case (cur_sel)
        gvu_pkg::MUL_SQX:  sqx   <= mul_prod[D2W-1:0];
        gvu_pkg::MUL_SQY:  d2    <= sqx + mul_prod[D2W-1:0];
        gvu_pkg::MUL_DEN:  den   <= mul_prod[gvu_pkg::DEN_W-1:0];
        gvu_pkg::MUL_GM:   gm    <= mul_prod[gvu_pkg::GM_W-1:0];
        gvu_pkg::MUL_NUMX: num_x <= {mul_prod[gvu_pkg::PROD_N_W-1:0],
                                     gvu_pkg::FRAC_SHIFT'(0)};
        default:           gm    <= gm;
      endcase
    end
  end

  // Configuration, target and accumulator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity     <= gvu_pkg::G_RESET;
      min_d2      <= gvu_pkg::DMIN_RESET;
      max_acc     <= gvu_pkg::AMAX_RESET;
      target_id   <= '0;
      target_x    <= '0;
      target_y    <= '0;
      tgt_mass    <= '0;
      target_vx   <= '0;
      target_vy   <= '0;
      acc_x       <= '0;
      acc_y       <= '0;
      close_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (gvu_pkg::reg_idx_t'(cfg_index))
          gvu_pkg::REG_GRAVITY:   gravity <= cfg_data[gvu_pkg::G_W-1:0];
          gvu_pkg::REG_MIN_DIST2: min_d2  <= cfg_data[gvu_pkg::DMIN_W-1:0];
          gvu_pkg::REG_MAX_ACCEL: max_acc <= cfg_data[gvu_pkg::AMAX_W-1:0];
          default:                gravity <= gravity;
        endcase
      end
      if (cmd.accept && in_kind == gvu_pkg::KIND_TARGET) begin
        target_id   <= in_body_id;
        target_x    <= in_pos_x;
        target_y    <= in_pos_y;
        tgt_mass    <= in_mass;
        target_vx   <= in_vel_x;
        target_vy   <= in_vel_y;
        acc_x       <= '0;
        acc_y       <= '0;
        close_count <= '0;
      end
      if (cmd.close_inc && close_count < SKIP_LIMIT) begin
        close_count <= close_count + SW'(1);
      end
      if (cmd.acc_upd) begin
        acc_x <= sat_add(acc_x, quo_x, neg_x);
        acc_y <= sat_add(acc_y, quo_y, neg_y);
      end
      if (cmd.result_wr) begin
        target_vx   <= vx_res;
        target_vy   <= vy_res;
        acc_x       <= '0;
        acc_y       <= '0;
        close_count <= '0;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_wr) begin
      out_vel_x  <= vx_res;
      out_vel_y  <= vy_res;
      out_status <= skip_upd;
      out_skips  <= close_count;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.result_wr |-> (!out_valid || out_ready))
    else $error("result written over a pending result");

  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> (!div_busy && !mul_busy))
    else $error("divider started while an earlier operation runs");

  a_acc_symmetric: assert property (@(posedge clk) disable iff (rst)
    (acc_x != {1'b1, {(AW-1){1'b0}}}) && (acc_y != {1'b1, {(AW-1){1'b0}}}))
    else $error("accumulator left its symmetric range");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    close_count <= SKIP_LIMIT)
    else $error("close count beyond its limit");
`endif

endmodule

### hw/rtl/gvu_ctrl.sv
module gvu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  gvu_pkg::status_t  stat,
  output gvu_pkg::cmd_t     cmd
);

  gvu_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gvu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gvu_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (stat.in_kind == gvu_pkg::KIND_TARGET || stat.in_same_id) begin
            state_next = stat.in_last ? gvu_pkg::ST_FINISH : gvu_pkg::ST_IDLE;
          end else begin
            state_next = gvu_pkg::ST_SQX;
          end
        end
      end
      gvu_pkg::ST_SQX:   if (stat.mul_done) state_next = gvu_pkg::ST_SQY;
      gvu_pkg::ST_SQY:   if (stat.mul_done) state_next = gvu_pkg::ST_CHECK;
      gvu_pkg::ST_CHECK: begin
        if (stat.too_close) begin
          state_next = stat.item_last ? gvu_pkg::ST_FINISH : gvu_pkg::ST_IDLE;
        end else begin
          state_next = gvu_pkg::ST_SQRT;
        end
      end
      gvu_pkg::ST_SQRT:  if (stat.sqrt_done) state_next = gvu_pkg::ST_DEN;
      gvu_pkg::ST_DEN:   if (stat.mul_done) state_next = gvu_pkg::ST_GM;
      gvu_pkg::ST_GM:    if (stat.mul_done) state_next = gvu_pkg::ST_NUMX;
      gvu_pkg::ST_NUMX:  if (stat.mul_done) state_next = gvu_pkg::ST_NUMY;
      gvu_pkg::ST_NUMY:  if (stat.mul_done) state_next = gvu_pkg::ST_DIV;
      gvu_pkg::ST_DIV:   if (stat.div_done) state_next = gvu_pkg::ST_ACC;
      gvu_pkg::ST_ACC: begin
        state_next = stat.item_last ? gvu_pkg::ST_FINISH : gvu_pkg::ST_IDLE;
      end
      gvu_pkg::ST_FINISH: if (stat.out_free) state_next = gvu_pkg::ST_IDLE;
      default:            state_next = gvu_pkg::ST_IDLE;
    endcase
  end

  // Units are launched on the edge that enters the state waiting for them.
  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = gvu_pkg::MUL_SQX;
    in_ready      = state == gvu_pkg::ST_IDLE;
    cmd.accept    = in_valid && in_ready;
    cmd.close_inc = (state == gvu_pkg::ST_CHECK) && stat.too_close;
    cmd.acc_upd   = state == gvu_pkg::ST_ACC;
    cmd.result_wr = (state == gvu_pkg::ST_FINISH) && stat.out_free;
    if (state_next != state) begin
      unique case (state_next)
        gvu_pkg::ST_SQX: begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = gvu_pkg::MUL_SQX;
        end
        gvu_pkg::ST_SQY: begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = gvu_pkg::MUL_SQY;
        end
        gvu_pkg::ST_DEN: begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = gvu_pkg::MUL_DEN;
        end
        gvu_pkg::ST_GM: begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = gvu_pkg::MUL_GM;
        end
        gvu_pkg::ST_NUMX: begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = gvu_pkg::MUL_NUMX;
        end
        gvu_pkg::ST_NUMY: begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = gvu_pkg::MUL_NUMY;
        end
        gvu_pkg::ST_SQRT: cmd.sqrt_start = 1'b1;
        gvu_pkg::ST_DIV:  cmd.div_start  = 1'b1;
        default:          cmd.sqrt_start = 1'b0;
      endcase
    end
  end

endmodule

### hw/rtl/gravity_velocity_update_core.sv
// Direct-sum 2D gravity velocity update. A request of kind 0 loads the target body
// (id, position, mass, velocity) and clears the acceleration sums and the close-skip
// count. Each request of kind 1 is another body whose pull G*m*diff/d^3 is added to the
// per-axis acceleration in Q48.16, saturating at plus or minus (2^63-1); a body with the
// target's id is ignored, and one whose squared distance is zero or below the minimum
// squared distance register is counted as a close skip instead. The request marked last
// yields one result: the old velocity plus the acceleration, saturated to 48 bits, with
// status 0, or the old velocity unchanged with status 1 when the target mass is zero or
// either acceleration magnitude exceeds the acceleration limit register. The reported
// velocity becomes the target's velocity for the next set, and the target stays loaded.
// Requests are handled one at a time. A target load or a same-id body needs no arithmetic,
// a close body runs the two squares, and a contributing body then runs the 33-step
// digit-by-digit square root, the products for d^3, G*m and both numerators, and the
// 63-step restoring divider (both axes in parallel), using a shared multiplier that works
// one 32-bit limb per cycle. The request marked last then writes the result, waiting
// while an earlier result is still uncollected. The result sits in an output register,
// so the next request is taken while it waits to be collected.
// Configuration registers are written through the cfg channel, which is always ready;
// writes are expected only while the block is idle.
module gravity_velocity_update_core #(
  parameter int MAX_BODIES = gvu_pkg::MAX_BODIES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  gvu_in_if.sink     body_in,
  gvu_out_if.source  result_out,
  gvu_cfg_if.sink    cfg
);

  gvu_pkg::cmd_t    cmd;
  gvu_pkg::status_t stat;

  // Register writes need no back-pressure.
  assign cfg.ready = 1'b1;

  // The controller sequences the shared arithmetic units for one body at a time.
  gvu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (body_in.valid),
    .in_ready (body_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the target, the sums, the arithmetic units and the output register.
  gvu_dp #(
    .MAX_BODIES (MAX_BODIES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_kind    (body_in.kind),
    .in_body_id (body_in.body_id),
    .in_pos_x   (body_in.pos_x),
    .in_pos_y   (body_in.pos_y),
    .in_mass    (body_in.mass),
    .in_vel_x   (body_in.vel_x),
    .in_vel_y   (body_in.vel_y),
    .in_last    (body_in.last),
    .cfg_valid  (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .out_vel_x  (result_out.new_vel_x),
    .out_vel_y  (result_out.new_vel_y),
    .out_status (result_out.status),
    .out_skips  (result_out.close_skips)
  );

endmodule
